// ===== hw/rtl/base64_stream_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define B64D_ASSERT_NEVER(lbl, cond, msg) \
  `B64D_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/b64d_pkg.sv =====
package b64d_pkg;

  localparam logic [7:0] SextetInvalid = 8'hFF;
  localparam logic [7:0] SextetPad     = 8'hFE;
  localparam logic [7:0] PadChar       = 8'h3D;  // '='

  localparam int unsigned FifoDepthDefault = 4;

  // One unit of work handed from the front end to the output side.
  typedef struct packed {
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [1:0] last_idx;  // index of the final byte to send
    logic       err;       // error result: one zero byte, status set
    logic       eos;       // final byte closes the string
  } cmd_t;

  // Standard alphabet lookup; returns a sextet, SextetPad or SextetInvalid.
  function automatic logic [7:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] r;
    r = SextetInvalid;
    if (c == PadChar) begin
      r = SextetPad;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      r = 8'd62;
    end else if (c == 8'h2F) begin
      r = 8'd63;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
`include "base64_stream_decoder_defines.svh"

module b64d_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    text_char_i,
  input  logic          final_char_i,
  input  logic          full_i,
  output logic          push_o,
  output b64d_pkg::cmd_t cmd_o
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] sext_q [3];
  logic       third_pad_q, third_pad_d;
  logic       short_q, short_d;
  logic       discard_q, discard_d;
  logic       accept;
  logic [7:0] v;
  logic       is_pad;
  logic       err;
  logic       wr_sext;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign v          = b64d_pkg::char_to_sextet(text_char_i);
  assign is_pad     = (v == b64d_pkg::SextetPad);

  assign err = (v == b64d_pkg::SextetInvalid) || short_q ||
               (is_pad && !pos_q[1]) ||
               ((pos_q == 2'd3) && third_pad_q && !is_pad) ||
               (final_char_i && (pos_q != 2'd3));

  always_comb begin
    pos_d       = pos_q;
    third_pad_d = third_pad_q;
    short_d     = short_q;
    discard_d   = discard_q;
    push_o      = 1'b0;
    wr_sext     = 1'b0;
    cmd_o.data0    = {sext_q[0], sext_q[1][5:4]};
    cmd_o.data1    = {sext_q[1][3:0], sext_q[2][5:2]};
    cmd_o.data2    = {sext_q[2][1:0], v[5:0]};
    cmd_o.last_idx = 2'd2;
    cmd_o.err      = 1'b0;
    cmd_o.eos      = final_char_i;
    if (third_pad_q) begin
      cmd_o.last_idx = 2'd0;
    end else if (is_pad) begin
      cmd_o.last_idx = 2'd1;
    end
    if (accept) begin
      if (discard_q) begin
        if (final_char_i) begin
          discard_d   = 1'b0;
          pos_d       = 2'd0;
          third_pad_d = 1'b0;
          short_d     = 1'b0;
        end
      end else if (err) begin
        push_o         = 1'b1;
        cmd_o.data0    = 8'd0;
        cmd_o.last_idx = 2'd0;
        cmd_o.err      = 1'b1;
        cmd_o.eos      = 1'b1;
        pos_d          = 2'd0;
        third_pad_d    = 1'b0;
        short_d        = 1'b0;
        discard_d      = !final_char_i;
      end else if (pos_q != 2'd3) begin
        wr_sext = 1'b1;
        pos_d   = pos_q + 2'd1;
        if (is_pad) begin
          third_pad_d = 1'b1;
        end
      end else begin
        push_o      = 1'b1;
        pos_d       = 2'd0;
        third_pad_d = 1'b0;
        if (final_char_i) begin
          short_d = 1'b0;
        end else if (third_pad_q || is_pad) begin
          short_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      third_pad_q <= 1'b0;
      short_q     <= 1'b0;
      discard_q   <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      third_pad_q <= third_pad_d;
      short_q     <= short_d;
      discard_q   <= discard_d;
    end
  end

  // Pad in the third slot leaves zero bits behind.
  always_ff @(posedge clk_i) begin
    if (wr_sext) begin
      sext_q[pos_q] <= is_pad ? 6'd0 : v[5:0];
    end
  end

  `B64D_ASSERT(discard_at_group_start, discard_q |-> (pos_q == 2'd0), "discard mid-group")
  `B64D_ASSERT(pad_only_before_slot3, third_pad_q |-> (pos_q == 2'd3), "stale third pad")

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
`include "base64_stream_decoder_defines.svh"

module b64d_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `B64D_ASSERT_NEVER(no_push_when_full, push_i && full_o, "push into full queue")
  `B64D_ASSERT_NEVER(no_pop_when_empty, pop_i && empty_o, "pop from empty queue")

endmodule

// ===== hw/rtl/b64d_back.sv =====
`include "base64_stream_decoder_defines.svh"

module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64d_pkg::cmd_t cmd_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     data_byte_o,
  output logic           status_o,
  output logic           eos_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] data_q;
  logic       status_q;
  logic       eos_q;
  logic       load;
  logic       last_byte;
  logic [7:0] sel_byte;

  assign load      = !empty_i && (!out_valid_q || out_ready_i);
  assign last_byte = (idx_q == cmd_i.last_idx);
  assign pop_o     = load && last_byte;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = cmd_i.data0;
      2'd1:    sel_byte = cmd_i.data1;
      default: sel_byte = cmd_i.data2;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = last_byte ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= sel_byte;
      status_q <= cmd_i.err;
      eos_q    <= cmd_i.eos && last_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;
  assign status_o    = status_q;
  assign eos_o       = eos_q;

  `B64D_ASSERT(mid_cmd_has_head, (idx_q != 2'd0) |-> !empty_i, "byte index without command")

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Base64 stream decoder (standard alphabet, '=' padding). The slave stream
// carries one encoded character per transaction, with tlast on the final
// character of a string; the master stream carries one decoded byte per
// transaction, with tlast on the last byte of a string and tuser set on an
// error result. The block accepts one character every clock cycle while
// the command queue has room, and sends one byte every clock cycle while
// tready is high and bytes are waiting; a group of four characters yields
// at most three bytes, so the output side keeps up with a full-rate input.
// Each decoded byte passes through the command queue and then the output
// register. s_axis_tready falls only while the command queue holds
// FifoDepth entries, which with the default depth happens only when the
// master side holds tready low. The front end classifies characters and
// tracks the group; each completed group or error becomes one entry in a
// short command queue (FifoDepth entries), and the output side drains it
// a byte at a time into a registered output stage. Malformed text (an
// invalid character, misplaced padding, text after a padded group, or a
// string that ends mid-group) produces a single zero byte with tuser and
// tlast set, after which input is dropped up to and including the
// character marked tlast; the consumer should discard any bytes it already
// received for that string.
module base64_stream_decoder #(
  parameter int unsigned FifoDepth = b64d_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Encoded character stream.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_char
  input  logic       s_axis_tlast_i,   // final_char
  // Decoded byte stream.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tuser_o,   // [0] status: 1 marks an error result
  output logic       m_axis_tlast_o    // end_of_string
);

  b64d_pkg::cmd_t push_cmd;
  b64d_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Front end: classifies and groups one char per cycle unless queue is full.
  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .text_char_i  (s_axis_tdata_i),
    .final_char_i (s_axis_tlast_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Command queue that decouples the character side from the byte side.
  b64d_fifo #(
    .Width ($bits(b64d_pkg::cmd_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  // Output side: serializes each command into bytes behind an output register.
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .data_byte_o (m_axis_tdata_o),
    .status_o    (m_axis_tuser_o),
    .eos_o       (m_axis_tlast_o)
  );

endmodule
